>>> hw/rtl/bbc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared types and character decoding for the bracket balance checker.
// ----------------------------------------------------------------------------
package bbc_pkg;

	typedef enum logic [1:0] {
		KIND_ROUND  = 2'd0,
		KIND_SQUARE = 2'd1,
		KIND_CURLY  = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	// ST_MATCHED doubles as "no failure" in the sticky failure register
	typedef enum logic [1:0] {
		ST_MATCHED   = 2'd0,
		ST_BAD_CLOSE = 2'd1,
		ST_UNCLOSED  = 2'd2,
		ST_OVERFLOW  = 2'd3
	} status_t;

	localparam int OPEN_LEFT_W = 7;
	localparam logic [7:0] CH_OPEN_ROUND   = 8'h28;
	localparam logic [7:0] CH_CLOSE_ROUND  = 8'h29;
	localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B;
	localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;
	localparam logic [7:0] CH_OPEN_CURLY   = 8'h7B;
	localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D;

	typedef struct packed {
		status_t                  status;
		logic [OPEN_LEFT_W-1:0]   open_left;
	} result_t;

	function automatic kind_t opener_kind(input logic [7:0] c);
		kind_t k;
		case (c)
			CH_OPEN_ROUND:  k = KIND_ROUND;
			CH_OPEN_SQUARE: k = KIND_SQUARE;
			CH_OPEN_CURLY:  k = KIND_CURLY;
			default:        k = KIND_NONE;
		endcase
		return k;
	endfunction

	function automatic kind_t closer_kind(input logic [7:0] c);
		kind_t k;
		case (c)
			CH_CLOSE_ROUND:  k = KIND_ROUND;
			CH_CLOSE_SQUARE: k = KIND_SQUARE;
			CH_CLOSE_CURLY:  k = KIND_CURLY;
			default:         k = KIND_NONE;
		endcase
		return k;
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/bbc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bbc_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 64
) (
	input  wire logic                             clk,
	input  wire logic                             we,
	input  wire logic [$clog2(DEPTH)-1:0]         waddr,
	input  wire logic [WIDTH-1:0]                 wdata,
	input  wire logic [$clog2(DEPTH)-1:0]         raddr,
	output logic      [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// read returns the old word when both ports hit the same address
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

>>> hw/rtl/bbc_stack.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bbc_stack
// Bracket stack: top entry in a register, the rest in RAM. The entry under
// the top is prefetched from RAM so that a pop can complete every cycle.
// ----------------------------------------------------------------------------
module bbc_stack #(
	parameter int DEPTH = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              acc,
	input  wire logic [7:0]        ch,
	input  wire logic              last,
	output bbc_pkg::result_t       res
);
	import bbc_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0] cnt_q, cnt_n, cnt_ld;
	status_t       fail_q, fail_n;
	kind_t         top_q, top_n;
	logic          fwd_q;
	kind_t         fwd_kind_q;
	kind_t         op_kind, cl_kind, second;
	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [1:0]    rd_data;
	logic [CW+6:0] cnt_wide;
	status_t       status_n;

	bbc_ram #(
		.WIDTH (2),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (top_q),
		.raddr (raddr),
		.rdata (rd_data)
	);

	always_comb begin
		op_kind = opener_kind(ch);
		cl_kind = closer_kind(ch);
		// take the word just written when the prefetch hit the write address
		second  = fwd_q ? fwd_kind_q : kind_t'(rd_data);
		cnt_n   = cnt_q;
		top_n   = top_q;
		fail_n  = fail_q;
		we      = 1'b0;
		waddr   = AW'(cnt_q - CW'(1));
		if (acc && fail_q == ST_MATCHED) begin
			if (op_kind != KIND_NONE) begin
				if (cnt_q == CW'(DEPTH)) begin
					fail_n = ST_OVERFLOW;
				end else begin
					// spill the old top into RAM
					we    = (cnt_q != '0);
					top_n = op_kind;
					cnt_n = cnt_q + CW'(1);
				end
			end else if (cl_kind != KIND_NONE) begin
				if (cnt_q == '0 || top_q != cl_kind) begin
					fail_n = ST_BAD_CLOSE;
				end else begin
					top_n = second;
					cnt_n = cnt_q - CW'(1);
				end
			end
		end
		cnt_ld = (acc && last) ? '0 : cnt_n;
		raddr  = (cnt_ld < CW'(2)) ? '0 : AW'(cnt_ld - CW'(2));
	end

	always_comb begin
		if (fail_n != ST_MATCHED) begin
			status_n = fail_n;
		end else if (cnt_n != '0) begin
			status_n = ST_UNCLOSED;
		end else begin
			status_n = ST_MATCHED;
		end
		cnt_wide = (CW+7)'(cnt_n);
		res.status = status_n;
		res.open_left = (cnt_wide > (CW+7)'(127)) ? OPEN_LEFT_W'(127)
		                                          : cnt_wide[OPEN_LEFT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			fail_q <= ST_MATCHED;
			fwd_q  <= 1'b0;
		end else begin
			cnt_q  <= cnt_ld;
			fail_q <= (acc && last) ? ST_MATCHED : fail_n;
			fwd_q  <= we;
		end
	end

	always_ff @(posedge clk) begin
		top_q      <= top_n;
		fwd_kind_q <= top_q;
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("stack count beyond depth");

	a_clear_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		acc && last |=> cnt_q == '0 && fail_q == ST_MATCHED)
		else $error("state not cleared after final character");

	a_fail_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		fail_q != ST_MATCHED && !(acc && last) |=> fail_q == $past(fail_q)
		&& cnt_q == $past(cnt_q))
		else $error("failed string changed state");

	a_push: assert property (@(posedge clk) disable iff (!arst_n)
		acc && !last && fail_q == ST_MATCHED && op_kind != KIND_NONE
		&& cnt_q != CW'(DEPTH) |=> cnt_q == $past(cnt_q) + CW'(1)
		&& top_q == $past(op_kind))
		else $error("push did not advance the stack");

endmodule
`default_nettype wire

>>> hw/rtl/bracket_balance_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bracket_balance_checker
// Balanced bracket check over a byte stream, one status per string.
// ----------------------------------------------------------------------------
// Takes one character per cycle while s_tready is high, with tlast on the
// final character of each string, and returns one status word in the cycle
// after that character is taken. Opening brackets are kept on a stack of
// DEPTH entries: the top in a register and the rest in a single RAM with a
// registered read, the entry under the top prefetched, so push, pop and the
// match compare never wait and a character is taken every cycle s_tready is high.
// The output register holds a status until the sink takes it; an input is
// held only while a status waits and the sink is not ready, and in the cycle
// the sink takes it the next character goes in as well. The RAM needs no
// clearing after reset.
module bracket_balance_checker #(
	parameter int DEPTH = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] ch
	input  wire logic        s_tlast,   // last
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata    // [1:0] status, [8:2] open_left, rest zero
);
	import bbc_pkg::*;

	logic    acc;
	result_t res;
	result_t res_q;

	assign s_tready = !m_tvalid || m_tready;
	assign acc      = s_tvalid && s_tready;

	bbc_stack #(
		.DEPTH (DEPTH)
	) u_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.acc    (acc),
		.ch     (s_tdata),
		.last   (s_tlast),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (acc && s_tlast) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && s_tlast) begin
			res_q <= res;
		end
	end

	assign m_tdata = {7'b0, res_q.open_left, res_q.status};

endmodule
`default_nettype wire
